@@ design/dlefr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlefr_pkg
// Shared types and codes for the DLE framed receive deframer.
// ----------------------------------------------------------------------------
package dlefr_pkg;

	// Result kinds as carried on the master-side tuser.
	localparam logic [2:0] KIND_DATA     = 3'd0;
	localparam logic [2:0] KIND_GOOD     = 3'd1;
	localparam logic [2:0] KIND_BADFCS   = 3'd2;
	localparam logic [2:0] KIND_OVERFLOW = 3'd3;
	localparam logic [2:0] KIND_FRAMING  = 3'd4;

	// Configuration register indexes.
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_FCS_CHECK   = 1'b1;

	// Configuration as seen by the frame controller.
	typedef struct packed {
		logic [7:0] max_payload;
		logic       fcs_check;
	} dlefr_cfg_t;

	// One result produced by a processed line byte.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic [2:0] kind;
		logic [7:0] length;
	} dlefr_result_t;

endpackage

@@ design/dlefr_fcs.sv @@
// ----------------------------------------------------------------------------
// dlefr_fcs
// One byte step of the table-driven 16-bit frame check sequence.
// ----------------------------------------------------------------------------
module dlefr_fcs import dlefr_pkg::*; (
	input  logic [15:0] fcs_in,
	input  logic [7:0]  data_in,
	output logic [15:0] fcs_out
);

	localparam logic [15:0] FCS_TABLE [256] = '{
		16'h0000,16'hC1C0,16'h81C1,16'h4001,16'h01C3,16'hC003,16'h8002,16'h41C2,16'h01C6,
		16'hC006,16'h8007,16'h41C7,16'h0005,16'hC1C5,16'h81C4,16'h4004,16'h01CC,16'hC00C,
		16'h800D,16'h41CD,16'h000F,16'hC1CF,16'h81CE,16'h400E,16'h000A,16'hC1CA,16'h81CB,
		16'h400B,16'h01C9,16'hC009,16'h8008,16'h41C8,16'h01D8,16'hC018,16'h8019,16'h41D9,
		16'h001B,16'hC1DB,16'h81DA,16'h401A,16'h001E,16'hC1DE,16'h81DF,16'h401F,16'h01DD,
		16'hC01D,16'h801C,16'h41DC,16'h0014,16'hC1D4,16'h81D5,16'h4015,16'h01D7,16'hC017,
		16'h8016,16'h41D6,16'h01D2,16'hC012,16'h8013,16'h41D3,16'h0011,16'hC1D1,16'h81D0,
		16'h4010,16'h01F0,16'hC030,16'h8031,16'h41F1,16'h0033,16'hC1F3,16'h81F2,16'h4032,
		16'h0036,16'hC1F6,16'h81F7,16'h4037,16'h01F5,16'hC035,16'h8034,16'h41F4,16'h003C,
		16'hC1FC,16'h81FD,16'h403D,16'h01FF,16'hC03F,16'h803E,16'h41FE,16'h01FA,16'hC03A,
		16'h803B,16'h41FB,16'h0039,16'hC1F9,16'h81F8,16'h4038,16'h0028,16'hC1E8,16'h81E9,
		16'h4029,16'h01EB,16'hC02B,16'h802A,16'h41EA,16'h01EE,16'hC02E,16'h802F,16'h41EF,
		16'h002D,16'hC1ED,16'h81EC,16'h402C,16'h01E4,16'hC024,16'h8025,16'h41E5,16'h0027,
		16'hC1E7,16'h81E6,16'h4026,16'h0022,16'hC1E2,16'h81E3,16'h4023,16'h01E1,16'hC021,
		16'h8020,16'h41E0,16'h01A0,16'hC060,16'h8061,16'h41A1,16'h0063,16'hC1A3,16'h81A2,
		16'h4062,16'h0066,16'hC1A6,16'h81A7,16'h4067,16'h01A5,16'hC065,16'h8064,16'h41A4,
		16'h006C,16'hC1AC,16'h81AD,16'h406D,16'h01AF,16'hC06F,16'h806E,16'h41AE,16'h01AA,
		16'hC06A,16'h806B,16'h41AB,16'h0069,16'hC1A9,16'h81A8,16'h4068,16'h0078,16'hC1B8,
		16'h81B9,16'h4079,16'h01BB,16'hC07B,16'h807A,16'h41BA,16'h01BE,16'hC07E,16'h807F,
		16'h41BF,16'h007D,16'hC1BD,16'h81BC,16'h407C,16'h01B4,16'hC074,16'h8075,16'h41B5,
		16'h0077,16'hC1B7,16'h81B6,16'h4076,16'h0072,16'hC1B2,16'h81B3,16'h4073,16'h01B1,
		16'hC071,16'h8070,16'h41B0,16'h0050,16'hC190,16'h8191,16'h4051,16'h0193,16'hC053,
		16'h8052,16'h4192,16'h0196,16'hC056,16'h8057,16'h4197,16'h0055,16'hC195,16'h8194,
		16'h4054,16'h019C,16'hC05C,16'h805D,16'h419D,16'h005F,16'hC19F,16'h819E,16'h405E,
		16'h005A,16'hC19A,16'h819B,16'h405B,16'h0199,16'hC059,16'h8058,16'h4198,16'h0188,
		16'hC048,16'h8049,16'h4189,16'h004B,16'hC18B,16'h818A,16'h404A,16'h004E,16'hC18E,
		16'h818F,16'h404F,16'h018D,16'hC04D,16'h804C,16'h418C,16'h0044,16'hC184,16'h8185,
		16'h4045,16'h0187,16'hC047,16'h8046,16'h4186,16'h0182,16'hC042,16'h8043,16'h4183,
		16'h0041,16'hC181,16'h8180,16'h4040
	};

	logic [15:0] entry;

	assign entry = FCS_TABLE[data_in ^ fcs_in[15:8]];

	// The old low byte moves up and is folded into the high half of the entry.
	assign fcs_out = {entry[15:8] ^ fcs_in[7:0], entry[7:0]};

endmodule

@@ design/dlefr_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlefr_ctrl
// Frame state machine: start hunt, destuffing, length limit and FCS check.
// ----------------------------------------------------------------------------
module dlefr_ctrl import dlefr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    line_byte,
	input  dlefr_cfg_t    cfg,
	output dlefr_result_t result
);

	localparam logic [7:0] BYTE_SYN = 8'h16;
	localparam logic [7:0] BYTE_DLE = 8'h10;
	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_ETX = 8'h03;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SYN    = 3'd1,
		PH_SYNDLE = 3'd2,
		PH_DATA   = 3'd3,
		PH_ESC    = 3'd4,
		PH_FCS_HI = 3'd5,
		PH_FCS_LO = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] fcs_q, fcs_d, fcs_next;
	logic [7:0]  fcs_hi_q, fcs_hi_d;
	logic [15:0] fcs_final;
	logic        at_limit;

	dlefr_fcs u_fcs (
		.fcs_in  (fcs_q),
		.data_in (line_byte),
		.fcs_out (fcs_next)
	);

	assign fcs_final = ~fcs_q;
	assign at_limit  = (count_q >= cfg.max_payload);

	// The FCS register takes the DLE of an escape as soon as it is seen, so an
	// escaped DLE needs only one table step and DLE ETX adds one for the ETX.
	always_comb begin
		phase_d          = phase_q;
		count_d          = count_q;
		fcs_d            = fcs_q;
		fcs_hi_d         = fcs_hi_q;
		result.valid     = 1'b0;
		result.data_byte = 8'd0;
		result.kind      = KIND_DATA;
		result.length    = count_q;
		case (phase_q)
			PH_SYN: begin
				if (line_byte == BYTE_DLE) begin
					phase_d = PH_SYNDLE;
				end else if (line_byte == BYTE_SYN) begin
					phase_d = PH_SYN;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_SYNDLE: begin
				if (line_byte == BYTE_STX) begin
					phase_d  = PH_DATA;
					count_d  = 8'd0;
					fcs_d    = 16'hFFFF;
					fcs_hi_d = 8'd0;
				end else if (line_byte == BYTE_SYN) begin
					phase_d = PH_SYN;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (line_byte == BYTE_DLE) begin
					phase_d = PH_ESC;
					fcs_d   = fcs_next;
				end else if (at_limit) begin
					phase_d      = PH_HUNT;
					result.valid = 1'b1;
					result.kind  = KIND_OVERFLOW;
				end else begin
					count_d          = count_q + 8'd1;
					fcs_d            = fcs_next;
					result.valid     = 1'b1;
					result.data_byte = line_byte;
					result.length    = count_q + 8'd1;
				end
			end
			PH_ESC: begin
				if (line_byte == BYTE_DLE) begin
					result.valid = 1'b1;
					if (at_limit) begin
						phase_d     = PH_HUNT;
						result.kind = KIND_OVERFLOW;
					end else begin
						phase_d          = PH_DATA;
						count_d          = count_q + 8'd1;
						result.data_byte = line_byte;
						result.length    = count_q + 8'd1;
					end
				end else if (line_byte == BYTE_ETX) begin
					phase_d = PH_FCS_HI;
					fcs_d   = fcs_next;
				end else begin
					phase_d      = PH_HUNT;
					result.valid = 1'b1;
					result.kind  = KIND_FRAMING;
				end
			end
			PH_FCS_HI: begin
				fcs_hi_d = line_byte;
				phase_d  = PH_FCS_LO;
			end
			PH_FCS_LO: begin
				phase_d      = PH_HUNT;
				result.valid = 1'b1;
				if (cfg.fcs_check && (fcs_hi_q != fcs_final[15:8] ||
						line_byte != fcs_final[7:0])) begin
					result.kind = KIND_BADFCS;
				end else begin
					result.kind = KIND_GOOD;
				end
			end
			default: begin
				phase_d = (line_byte == BYTE_SYN) ? PH_SYN : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			count_q  <= 8'd0;
			fcs_q    <= 16'hFFFF;
			fcs_hi_q <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			fcs_q    <= fcs_d;
			fcs_hi_q <= fcs_hi_d;
		end
	end

endmodule

@@ design/dle_framed_receive_deframer_core.sv @@
// ----------------------------------------------------------------------------
// dle_framed_receive_deframer_core
// Receive deframer for SYN DLE STX framed, DLE stuffed lines with 16-bit FCS.
// ----------------------------------------------------------------------------
// The block takes one raw line byte per transfer on the slave side and hunts
// for the start sequence SYN DLE STX. Inside a frame it delivers destuffed
// payload bytes (DLE DLE collapses to one DLE) on the master side, each with
// the running payload length; DLE ETX closes the payload and the following
// two raw bytes are taken as the received FCS, high byte first. At frame end
// a single status transfer reports a good frame, a bad FCS (only when the
// check is enabled), an overflow abort or a framing error; status transfers
// carry a zero data byte. A line byte is accepted in every clock cycle while
// results are being taken, and each byte passes first through the input
// register and then through the result register. Its throughput is bounded
// by the frame state loop, which does one table step of the FCS per byte.
// Configuration writes take effect at once and should be made while the
// block is idle.
// ----------------------------------------------------------------------------
module dle_framed_receive_deframer_core import dlefr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	// Line bytes in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] line_byte
	// Results out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] frame_length
	output logic [2:0]  m_tuser    // [2:0] item_kind
);

	// Configuration registers.
	logic [7:0]    max_payload_q;
	logic          fcs_check_q;
	dlefr_cfg_t    cfg;

	// Input register stage.
	logic          valid_s1;
	logic [7:0]    byte_s1;

	// Result register stage.
	logic          valid_s2;
	logic [7:0]    out_byte_s2;
	logic [2:0]    kind_s2;
	logic [7:0]    length_s2;

	logic          advance;
	logic          step;
	dlefr_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 8'd174;
			fcs_check_q   <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == REG_MAX_PAYLOAD) begin
				max_payload_q <= wr_data;
			end else if (wr_index == REG_FCS_CHECK) begin
				fcs_check_q <= wr_data[0];
			end
		end
	end

	assign cfg.max_payload = max_payload_q;
	assign cfg.fcs_check   = fcs_check_q;

	// The held byte moves on whenever the result register is free or is being
	// emptied in this cycle, so a result that is being taken does not block the input.
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	dlefr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.line_byte (byte_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// A processed byte that yields no result simply leaves the result
	// register empty once its previous content has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			out_byte_s2 <= result.data_byte;
			kind_s2     <= result.kind;
			length_s2   <= result.length;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {length_s2, out_byte_s2};
	assign m_tuser  = kind_s2;

	// Status transfers always carry a zero data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata[7:0] == 8'd0))
		else $error("status transfer with non-zero data byte");

	// A payload byte always counts itself, so its length is never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_DATA) |-> (m_tdata[15:8] != 8'd0))
		else $error("payload transfer with zero frame length");

	// A held line byte that cannot advance stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a stalled byte");

	// A result kind beyond the framing error code is never produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= KIND_FRAMING))
		else $error("undefined result kind");

endmodule

@@ test/dle_deframer_check_pkg.sv @@
// ----------------------------------------------------------------------------
// dle_deframer_check_pkg
// Line byte codes, FCS step and result scoreboard for the deframer testbench.
// ----------------------------------------------------------------------------
package dle_deframer_check_pkg;
	import dlefr_pkg::*;

	localparam logic [7:0] LINE_SYN = 8'h16;
	localparam logic [7:0] LINE_DLE = 8'h10;
	localparam logic [7:0] LINE_STX = 8'h02;
	localparam logic [7:0] LINE_ETX = 8'h03;

	// One byte step of the frame check sequence. The table entry is the reflected
	// CRC-16 (polynomial 0xA001) of the index, with its two bytes swapped.
	function automatic logic [15:0] fcs_step(logic [15:0] fcs, logic [7:0] b);
		logic [15:0] crc;
		logic [15:0] entry;
		int i;
		crc = {8'h00, b ^ fcs[15:8]};
		for (i = 0; i < 8; i++)
			crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
		entry = {crc[7:0], crc[15:8]};
		return {entry[15:8] ^ fcs[7:0], entry[7:0]};
	endfunction

	typedef enum logic [2:0] {
		HUNT_SYN, GOT_SYN, GOT_SYN_DLE, IN_PAYLOAD, AFTER_DLE, FCS_HIGH, FCS_LOW
	} rx_phase_e;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] kind;
		logic [7:0] length;
	} deframed_item_t;

	class deframed_stream_scoreboard;
		logic [7:0]     max_payload;
		bit             fcs_check;
		rx_phase_e      phase;
		logic [7:0]     payload_count;
		logic [15:0]    running_fcs;
		logic [7:0]     fcs_high;
		deframed_item_t expected_items[$];
		int             mismatches;
		int             checked;
		int             kind_seen[5];

		function new();
			max_payload   = 8'd174;
			fcs_check     = 1'b0;
			phase         = HUNT_SYN;
			payload_count = 8'd0;
			running_fcs   = 16'hFFFF;
			fcs_high      = 8'd0;
			mismatches    = 0;
			checked       = 0;
			foreach (kind_seen[k])
				kind_seen[k] = 0;
		endfunction

		function void write_register(logic index, logic [7:0] value);
			case (index)
				REG_MAX_PAYLOAD: max_payload = value;
				REG_FCS_CHECK:   fcs_check = value[0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return expected_items.size();
		endfunction

		function void close_frame(logic [2:0] kind);
			phase = HUNT_SYN;
			expected_items.push_back('{8'h00, kind, payload_count});
		endfunction

		function void take_payload(logic [7:0] b);
			if (payload_count >= max_payload) begin
				close_frame(KIND_OVERFLOW);
			end else begin
				payload_count = payload_count + 8'd1;
				running_fcs = fcs_step(running_fcs, b);
				phase = IN_PAYLOAD;
				expected_items.push_back('{b, KIND_DATA, payload_count});
			end
		endfunction

		// Advances the receive state by one accepted line byte.
		function void note_line_byte(logic [7:0] b);
			logic [15:0] sent_fcs;
			case (phase)
				GOT_SYN:
					phase = (b == LINE_DLE) ? GOT_SYN_DLE : (b == LINE_SYN) ? GOT_SYN : HUNT_SYN;
				GOT_SYN_DLE: begin
					if (b == LINE_STX) begin
						phase = IN_PAYLOAD;
						payload_count = 8'd0;
						running_fcs = 16'hFFFF;
						fcs_high = 8'd0;
					end else begin
						phase = (b == LINE_SYN) ? GOT_SYN : HUNT_SYN;
					end
				end
				IN_PAYLOAD: begin
					if (b == LINE_DLE)
						phase = AFTER_DLE;
					else
						take_payload(b);
				end
				AFTER_DLE: begin
					if (b == LINE_DLE) begin
						take_payload(b);
					end else if (b == LINE_ETX) begin
						running_fcs = fcs_step(fcs_step(running_fcs, LINE_DLE), LINE_ETX);
						phase = FCS_HIGH;
					end else begin
						close_frame(KIND_FRAMING);
					end
				end
				FCS_HIGH: begin
					fcs_high = b;
					phase = FCS_LOW;
				end
				FCS_LOW: begin
					sent_fcs = ~running_fcs;
					if (fcs_check && {fcs_high, b} != sent_fcs)
						close_frame(KIND_BADFCS);
					else
						close_frame(KIND_GOOD);
				end
				default:
					phase = (b == LINE_SYN) ? GOT_SYN : HUNT_SYN;
			endcase
		endfunction

		function void check_result(logic [7:0] out_byte, logic [2:0] kind, logic [7:0] length);
			deframed_item_t want;
			checked++;
			if (kind < 3'd5)
				kind_seen[kind]++;
			if (expected_items.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISCOMPARE: unexpected result byte %02h kind %0d length %0d",
						out_byte, kind, length);
				return;
			end
			want = expected_items.pop_front();
			if (out_byte !== want.out_byte || kind !== want.kind || length !== want.length) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISCOMPARE: expected byte %02h kind %0d length %0d, got byte %02h kind %0d length %0d",
						want.out_byte, want.kind, want.length, out_byte, kind, length);
			end
		endfunction
	endclass

endpackage

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DLE framed receive deframer core.
// ----------------------------------------------------------------------------
// Line bytes are offered on the slave side with random gaps; every accepted
// transfer advances a scoreboard that keeps its own copy of the frame state
// and lists the payload and status transfers the block owes. The master side
// stalls at random and each result transfer is compared field by field with
// the oldest outstanding expectation. A short directed sequence covers the
// start sequence restarts, stuffing, empty frames and every status kind, and
// then several register settings each get a batch of random frames.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dlefr_pkg::*;
	import dle_deframer_check_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	// A byte passes through the input and result registers; this covers bytes that leave no result.
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;

	typedef enum {CLOSE_FCS_OK, CLOSE_FCS_BAD, CLOSE_STRAY, CLOSE_NONE} frame_close_e;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        wr_en    = 1'b0;
	logic        wr_index = 1'b0;
	logic [7:0]  wr_data  = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [7:0] line_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] out_byte, [15:8] frame_length
	logic [2:0]  m_tuser;           // [2:0] item_kind

	deframed_stream_scoreboard frame_sb = new();

	int  cycle_count    = 0;
	int  bytes_accepted = 0;
	int  frame_bytes    = 0;
	int  frames_offered = 0;
	int  settings_used  = 0;
	int  cur_max        = 174;
	bit  cur_check      = 1'b0;
	bit  sender_burst   = 1'b0;
	bit  hold_requested = 1'b0;

	dle_framed_receive_deframer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a hung handshake must not keep the run alive for ever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding.",
				frame_sb.outstanding());
			$display("dle_framed_receive_deframer_core: mismatch");
			$finish;
		end
	end

	// Idle length for either side: mostly a short gap, now and then a long pause.
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side. Values are read straight after the edge, so they are the ones
	// the block saw at that edge; tready for the next cycle is set once per edge.
	initial begin : result_sink
		int stall_left;
		int calm_left;
		int hold_left;
		bit hold_done;
		int r;
		stall_left = 0;
		calm_left  = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				frame_sb.check_result(m_tdata[7:0], m_tuser, m_tdata[15:8]);
			if (hold_requested && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				// Long hold-off: the sender keeps going, so the block fills and
				// must push back on its input.
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					r = $urandom_range(99);
					if (r < 3)
						calm_left = $urandom_range(50, 200);
					else if (r < 35)
						stall_left = pick_idle_len();
				end
			end
		end
	end

	// Offers one line byte and returns once the transfer has been accepted.
	// tvalid is left high so that a back-to-back byte needs no second update.
	task automatic send_line_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!sender_burst && $urandom_range(99) >= 60)
			gap = pick_idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_accepted++;
		frame_sb.note_line_byte(b);
	endtask

	// Waits until every owed result has been taken and the pipeline is empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after its last write.
	task automatic write_register(input logic index, input logic [7:0] value);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= value;
		@(posedge clk);
		frame_sb.write_register(index, value);
	endtask

	task automatic offer_bytes(input logic [7:0] seq[$]);
		foreach (seq[k])
			send_line_byte(seq[k]);
	endtask

	// Builds one frame: optional line noise, the start sequence, a stuffed
	// payload of the given length and the chosen way of closing it.
	task automatic offer_frame(input int len, input frame_close_e close_kind,
		input int noise_len);
		logic [7:0]  frame_q[$];
		logic [15:0] fcs;
		logic [7:0]  b;
		int          r;
		int          i;
		fcs = 16'hFFFF;
		for (i = 0; i < noise_len; i++) begin
			// Noise leans on the start codes so that broken starts are common.
			r = $urandom_range(99);
			frame_q.push_back(r < 30 ? LINE_SYN : r < 50 ? LINE_DLE : r < 60 ? LINE_STX :
				8'($urandom_range(255)));
		end
		frame_q.push_back(LINE_SYN);
		frame_q.push_back(LINE_DLE);
		frame_q.push_back(LINE_STX);
		for (i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 20)
				b = LINE_DLE;
			else if (r < 22)
				b = LINE_SYN;
			else if (r < 25)
				b = LINE_STX;
			else if (r < 28)
				b = LINE_ETX;
			else
				b = 8'($urandom_range(255));
			frame_q.push_back(b);
			if (b == LINE_DLE)
				frame_q.push_back(LINE_DLE);
			fcs = fcs_step(fcs, b);
		end
		case (close_kind)
			CLOSE_FCS_OK, CLOSE_FCS_BAD: begin
				fcs = ~fcs_step(fcs_step(fcs, LINE_DLE), LINE_ETX);
				if (close_kind == CLOSE_FCS_BAD)
					fcs = fcs ^ (16'd1 << $urandom_range(15));
				frame_q.push_back(LINE_DLE);
				frame_q.push_back(LINE_ETX);
				frame_q.push_back(fcs[15:8]);
				frame_q.push_back(fcs[7:0]);
			end
			CLOSE_STRAY: begin
				do
					b = 8'($urandom_range(255));
				while (b == LINE_DLE || b == LINE_ETX);
				frame_q.push_back(LINE_DLE);
				frame_q.push_back(b);
			end
			default: ;
		endcase
		frame_bytes += frame_q.size() - noise_len;
		frames_offered++;
		offer_bytes(frame_q);
	endtask

	task automatic offer_random_frame();
		int           r;
		int           len;
		bit           big;
		frame_close_e close_kind;
		big = cur_max > 32;
		// Most frames are short; the length limit and one past it come up now
		// and then, and rarely when the limit is large.
		r = $urandom_range(99);
		if (r < (big ? 94 : 70))
			len = $urandom_range(0, cur_max < 12 ? cur_max : 12);
		else if (r < (big ? 96 : 82))
			len = cur_max;
		else if (r < (big ? 98 : 92))
			len = cur_max + 1;
		else
			len = $urandom_range(0, cur_max + 2);
		r = $urandom_range(99);
		if (r < 7)
			close_kind = CLOSE_STRAY;
		else if (r < 11)
			close_kind = CLOSE_NONE;
		else if (r < (cur_check ? 31 : 20))
			close_kind = CLOSE_FCS_BAD;
		else
			close_kind = CLOSE_FCS_OK;
		sender_burst = $urandom_range(99) < 20;
		offer_frame(len, close_kind, $urandom_range(99) < 20 ? $urandom_range(1, 4) : 0);
	endtask

	task automatic apply_setting(input int max_bytes, input bit check);
		settle();
		write_register(REG_MAX_PAYLOAD, 8'(max_bytes));
		write_register(REG_FCS_CHECK, {7'd0, check});
		wr_en     <= 1'b0;
		cur_max   = max_bytes;
		cur_check = check;
		settings_used++;
	endtask

	task automatic run_random_frames(input int max_bytes, input bit check, input int budget,
		input bit press);
		int start_bytes;
		apply_setting(max_bytes, check);
		if (press)
			hold_requested = 1'b1;
		start_bytes = frame_bytes;
		while (frame_bytes - start_bytes < budget)
			offer_random_frame();
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings. A broken start with restarts on SYN, then a frame with
		// extreme payload bytes, an escaped DLE and FCS bytes taken raw.
		offer_bytes('{LINE_SYN, LINE_SYN, LINE_DLE, LINE_SYN, LINE_DLE, LINE_STX,
			8'h00, 8'hFF, LINE_DLE, LINE_DLE, LINE_DLE, LINE_ETX, LINE_DLE, LINE_SYN});
		// Empty frame, then a stray escape straight after the start.
		offer_bytes('{LINE_SYN, LINE_DLE, LINE_STX, LINE_DLE, LINE_ETX, 8'hAB, 8'hCD});
		offer_bytes('{LINE_SYN, LINE_DLE, LINE_STX, LINE_DLE, 8'h41});

		// One payload byte allowed and the check on: a corrupted FCS and an
		// overflow on the second payload byte.
		apply_setting(1, 1'b1);
		offer_frame(1, CLOSE_FCS_BAD, 0);
		offer_frame(2, CLOSE_FCS_OK, 0);

		run_random_frames(16, 1'b1, 400, 1'b0);
		run_random_frames(255, 1'b1, 500, 1'b1);
		run_random_frames(1, 1'b0, 150, 1'b0);
		run_random_frames(0, 1'b1, 60, 1'b0);
		run_random_frames(100, 1'b0, 250, 1'b0);
		run_random_frames(5, 1'b1, 340, 1'b0);

		settle();
		$display("Covered %0d line bytes in %0d frames over %0d register settings.",
			bytes_accepted, frames_offered, settings_used);
		$display("Checked %0d results: %0d payload, %0d good, %0d bad FCS, %0d overflow, %0d framing.",
			frame_sb.checked, frame_sb.kind_seen[KIND_DATA], frame_sb.kind_seen[KIND_GOOD],
			frame_sb.kind_seen[KIND_BADFCS], frame_sb.kind_seen[KIND_OVERFLOW],
			frame_sb.kind_seen[KIND_FRAMING]);
		if (frame_sb.mismatches == 0 && frame_sb.outstanding() == 0) begin
			$display("dle_framed_receive_deframer_core: match");
		end else begin
			$display("%0d miscompares, %0d results still owed.", frame_sb.mismatches,
				frame_sb.outstanding());
			$display("dle_framed_receive_deframer_core: mismatch");
		end
		$finish;
	end

endmodule
